FILE: rtl/picture_column_post_decoder_top_defines.svh
// Assertion macros for the picture column post decoder.
// Used by picture_column_post_decoder_top; expects clk and rst in scope.
`ifndef PICTURE_COLUMN_POST_DECODER_TOP_DEFINES_SVH
`define PICTURE_COLUMN_POST_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PCPD_ASSERT_NOW(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("pcpd same-cycle check failed");

// Next-cycle implication, checked out of reset
`define PCPD_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error("pcpd next-cycle check failed");

`endif

FILE: rtl/pcpd_pkg.sv
// Shared types and constants of the picture column post decoder.
// No dependencies; used by pcpd_parser and picture_column_post_decoder_top.
`default_nettype none

package pcpd_pkg;

  // Picture limits
  localparam int MAX_WIDTH = 512;
  localparam int MAX_ROWS  = 512;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 9;
  localparam int ADDR_W  = 18;
  localparam int DIM_W   = 10;
  localparam int EFF_W_W = $clog2(MAX_WIDTH + 1);

  // Byte that closes a column
  localparam logic [BYTE_W-1:0] TERMINATOR = 8'hFF;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_PICTURE_WIDTH  = 1'b0,
    REG_PICTURE_HEIGHT = 1'b1
  } cfg_reg_t;

  // One parsed result between parser and address stage
  typedef struct packed {
    logic             col_end;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [BYTE_W-1:0] value;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/pcpd_parser.sv
// Post parser: walks top offset, length, pads and pixel bytes of a column.
// Depends on pcpd_pkg. State advances on each accepted byte.
`default_nettype none

module pcpd_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [pcpd_pkg::BYTE_W-1:0] stream_byte,
  input  wire logic [pcpd_pkg::COL_W-1:0]  column_index,
  input  wire logic                        column_start,
  output logic                             item_valid,
  output pcpd_pkg::item_t                  item
);

  typedef enum logic [2:0] {
    PH_TOP  = 3'd0,
    PH_LEN  = 3'd1,
    PH_PAD1 = 3'd2,
    PH_PIX  = 3'd3,
    PH_PAD2 = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  phase_t                      phase, phase_next, phase_cur;
  logic [pcpd_pkg::BYTE_W-1:0] post_top, post_top_next;
  logic [pcpd_pkg::BYTE_W-1:0] post_remaining, post_remaining_next;
  logic [pcpd_pkg::BYTE_W-1:0] post_row_index, post_row_index_next;
  logic [pcpd_pkg::BYTE_W-1:0] remaining_dec;

  // A column start always restarts at the top offset
  assign phase_cur     = column_start ? PH_TOP : phase;
  assign remaining_dec = post_remaining - 8'd1;

  // Next state and result for the byte on the inputs
  always_comb begin
    phase_next          = phase_cur;
    post_top_next       = post_top;
    post_remaining_next = post_remaining;
    post_row_index_next = post_row_index;
    item_valid          = 1'b0;
    item.col_end        = 1'b0;
    item.col            = column_index;
    item.row            = pcpd_pkg::ROW_W'(post_top) + pcpd_pkg::ROW_W'(post_row_index);
    item.value          = stream_byte;
    unique case (phase_cur)
      PH_TOP: begin
        if (stream_byte == pcpd_pkg::TERMINATOR) begin
          phase_next   = PH_DONE;
          item_valid   = 1'b1;
          item.col_end = 1'b1;
          item.row     = '0;
          item.value   = '0;
        end else begin
          post_top_next = stream_byte;
          phase_next    = PH_LEN;
        end
      end
      PH_LEN: begin
        post_remaining_next = stream_byte;
        post_row_index_next = '0;
        phase_next          = PH_PAD1;
      end
      PH_PAD1: begin
        phase_next = (post_remaining != '0) ? PH_PIX : PH_PAD2;
      end
      PH_PIX: begin
        item_valid          = 1'b1;
        post_remaining_next = remaining_dec;
        post_row_index_next = post_row_index + 8'd1;
        if (remaining_dec == '0) begin
          phase_next = PH_PAD2;
        end
      end
      PH_PAD2: begin
        phase_next = PH_TOP;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TOP;
      post_top       <= '0;
      post_remaining <= '0;
      post_row_index <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      post_top       <= post_top_next;
      post_remaining <= post_remaining_next;
      post_row_index <= post_row_index_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/picture_column_post_decoder_top.sv
// Top level of the picture column post decoder: stream ports, config port,
// parsed-item register and address stage. Depends on pcpd_pkg, pcpd_parser
// and picture_column_post_decoder_top_defines.svh.
`default_nettype none

// Takes one byte of column post data per cycle and gives at most one result
// per byte: a pixel write (column, row, row*width+column, value), an
// overflowed pixel with the write cleared, or a column end marker. The parser
// decides the item into the parsed-item register, then the second stage does
// the row-times-width multiply and the height check into the output register.
// The stages are elastic, so a byte is taken every cycle as long as the result
// side keeps up; while a result waits, bytes are still taken until one yields
// an item. Write picture_width and picture_height only while idle; both reset
// to 1. Widths above 512 act as 512.
`include "picture_column_post_decoder_top_defines.svh"

module picture_column_post_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input bytes
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // stream_byte[7:0], column_index[16:8], zero pad
  input  wire logic [0:0]  s_tuser,  // column_start
  // Results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // pixel_column[8:0], pixel_row[17:9],
                                     // pixel_address[35:18], pixel_value[43:36], zero pad
  output logic [2:0]       m_tuser,  // pixel_write, column_end, row_overflow
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam int PROD_W = pcpd_pkg::ROW_W + pcpd_pkg::EFF_W_W + 1;

  logic [pcpd_pkg::DIM_W-1:0]   picture_width;
  logic [pcpd_pkg::DIM_W-1:0]   picture_height;
  logic [pcpd_pkg::EFF_W_W-1:0] width_eff;

  logic            in_accept;
  logic            item_valid;
  pcpd_pkg::item_t item;

  logic            s1_valid;
  pcpd_pkg::item_t s1_item;
  logic            s1_ready;
  logic            s2_ready;
  logic            s1_move;

  logic [PROD_W-1:0]           addr_full;
  logic                        over;
  logic                        out_write;
  logic                        out_end;
  logic                        out_over;
  logic [pcpd_pkg::COL_W-1:0]  out_col;
  logic [pcpd_pkg::ROW_W-1:0]  out_row;
  logic [pcpd_pkg::ADDR_W-1:0] out_addr;
  logic [pcpd_pkg::BYTE_W-1:0] out_value;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      picture_width  <= pcpd_pkg::DIM_W'(1);
      picture_height <= pcpd_pkg::DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcpd_pkg::REG_PICTURE_WIDTH:  picture_width  <= cfg_data;
        pcpd_pkg::REG_PICTURE_HEIGHT: picture_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake chain
  assign s2_ready  = !m_tvalid || m_tready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s1_move   = s1_valid && s2_ready;
  assign s_tready  = s1_ready;
  assign in_accept = s_tvalid && s_tready;

  pcpd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .stream_byte  (s_tdata[7:0]),
    .column_index (s_tdata[16:8]),
    .column_start (s_tuser[0]),
    .item_valid   (item_valid),
    .item         (item)
  );

  // Parsed-item register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept && item_valid) begin
      s1_valid <= 1'b1;
    end else if (s2_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && item_valid) begin
      s1_item <= item;
    end
  end

  // Address and height check
  assign width_eff = (32'(picture_width) < pcpd_pkg::MAX_WIDTH) ?
                     pcpd_pkg::EFF_W_W'(picture_width) :
                     pcpd_pkg::EFF_W_W'(pcpd_pkg::MAX_WIDTH);
  assign addr_full = PROD_W'(s1_item.row) * PROD_W'(width_eff) + PROD_W'(s1_item.col);
  assign over      = (32'(s1_item.row) >= 32'(picture_height)) ||
                     (32'(s1_item.row) >= pcpd_pkg::MAX_ROWS);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_col <= s1_item.col;
      if (s1_item.col_end) begin
        out_write <= 1'b0;
        out_end   <= 1'b1;
        out_over  <= 1'b0;
        out_row   <= '0;
        out_addr  <= '0;
        out_value <= '0;
      end else begin
        out_write <= !over;
        out_end   <= 1'b0;
        out_over  <= over;
        out_row   <= s1_item.row;
        out_addr  <= pcpd_pkg::ADDR_W'(addr_full);
        out_value <= s1_item.value;
      end
    end
  end

  assign m_tdata = {4'd0, out_value, out_addr, out_row, out_col};
  assign m_tuser = {out_over, out_end, out_write};

  // Checks
  `PCPD_ASSERT_NOW(a_end_no_pixel, m_tvalid && m_tuser[1], !m_tuser[0] && !m_tuser[2])
  `PCPD_ASSERT_NOW(a_write_not_over, m_tvalid && m_tuser[0], !m_tuser[2])
  `PCPD_ASSERT_NEXT(a_item_held, s1_valid && !s2_ready, s1_valid)

endmodule

`default_nettype wire

FILE: bench/picture_column_post_decoder_top_tb.sv
// Self-checking bench for picture_column_post_decoder_top: feeds column post streams,
// predicts every pixel write / column end and compares against the result stream.
// Depends on pcpd_pkg and the RTL of the decoder.
`timescale 1ns / 1ps

module picture_column_post_decoder_top_tb;

  localparam int IDLE_LIMIT   = 3000;  // cycles without any transaction
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;     // two-stage pipe plus margin
  localparam int PHASE_BYTES  = 160;
  localparam int N_PHASES     = 7;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    EXP_TOP, EXP_LEN, EXP_PAD1, EXP_PIX, EXP_PAD2, EXP_DONE
  } parse_state_t;

  typedef struct packed {
    logic        write_en;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [17:0] addr;
    logic [7:0]  value;
    logic        col_end;
    logic        overflow;
  } pixel_result_t;

  // Directed row: input byte plus a hand-written result where typed is set
  typedef struct packed {
    logic [7:0]  data;
    logic [8:0]  col;
    logic        start;
    logic        typed;
    logic        has_res;
    logic        write_en;
    logic [8:0]  row;
    logic [17:0] addr;
    logic        col_end;
    logic        overflow;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [9:0]  cfg_data;

  // Predictor state and registers
  parse_state_t parse_state;
  logic [7:0]   post_top;
  logic [7:0]   post_left;
  logic [7:0]   post_index;
  logic [9:0]   pic_width;
  logic [9:0]   pic_height;

  pixel_result_t pixel_queue [$];
  int            mismatches;
  int            idle_cycles = 0;
  int            burst_left;
  bit            hold_req;

  // Reset config (width 1, height 1): all results can be read off by hand
  script_row_t dir_script [0:24] = '{
    '{8'h00, 9'd511, 1'b1, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // top 0
    '{8'h02, 9'd511, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // len 2
    '{8'h5A, 9'd511, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // pad
    '{8'h00, 9'd511, 1'b0, 1'b1, 1'b1, 1'b1, 9'd0,   18'd511, 1'b0, 1'b0}, // pixel row 0
    '{8'hFF, 9'd511, 1'b0, 1'b1, 1'b1, 1'b0, 9'd1,   18'd512, 1'b0, 1'b1}, // row 1 over
    '{8'h00, 9'd511, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // pad
    '{8'h00, 9'd511, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // top 0
    '{8'h00, 9'd511, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // empty post
    '{8'h33, 9'd511, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // pad
    '{8'h44, 9'd511, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // pad
    '{8'hFF, 9'd511, 1'b0, 1'b1, 1'b1, 1'b0, 9'd0,   18'd0,   1'b1, 1'b0}, // terminator
    '{8'h12, 9'd511, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // ignored
    '{8'hFF, 9'd511, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // ignored
    '{8'hFF, 9'd0,   1'b1, 1'b1, 1'b1, 1'b0, 9'd0,   18'd0,   1'b1, 1'b0}, // empty column
    '{8'hFE, 9'd0,   1'b1, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // top 254
    '{8'hFF, 9'd0,   1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // len 255
    '{8'h00, 9'd0,   1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // pad
    '{8'h80, 9'd0,   1'b0, 1'b1, 1'b1, 1'b0, 9'd254, 18'd254, 1'b0, 1'b1}, // row 254
    '{8'h81, 9'd0,   1'b0, 1'b0, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0},
    '{8'h0A, 9'd6,   1'b1, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0}, // start mid-post
    '{8'h01, 9'd6,   1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0},
    '{8'h00, 9'd6,   1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0},
    '{8'hC3, 9'd6,   1'b0, 1'b0, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0},
    '{8'h00, 9'd6,   1'b0, 1'b1, 1'b0, 1'b0, 9'd0,   18'd0,   1'b0, 1'b0},
    '{8'hFF, 9'd6,   1'b0, 1'b1, 1'b1, 1'b0, 9'd0,   18'd0,   1'b1, 1'b0}
  };

  // Register settings per random phase; out-of-range values included
  logic [9:0] width_plan  [N_PHASES] = '{10'd512, 10'd1, 10'd512, 10'd0, 10'd1023,
                                         10'd1, 10'd300};
  logic [9:0] height_plan [N_PHASES] = '{10'd512, 10'd512, 10'd1, 10'd0, 10'd1023,
                                         10'd1, 10'd200};

  picture_column_post_decoder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Column post parser: returns 1 when the byte yields a result
  function automatic bit decode_post_byte(input logic [7:0] data, input logic [8:0] col,
                                          input logic start, output pixel_result_t res);
    parse_state_t st;
    int           eff_w;
    int           eff_h;
    int           addr_i;
    logic [8:0]   row;
    res = '0;
    st = start ? EXP_TOP : parse_state;
    case (st)
      EXP_TOP: begin
        if (data == pcpd_pkg::TERMINATOR) begin
          parse_state = EXP_DONE;
          res.col = col;
          res.col_end = 1'b1;
          return 1'b1;
        end
        post_top = data;
        parse_state = EXP_LEN;
      end
      EXP_LEN: begin
        post_left = data;
        post_index = 8'd0;
        parse_state = EXP_PAD1;
      end
      EXP_PAD1: parse_state = (post_left != 8'd0) ? EXP_PIX : EXP_PAD2;
      EXP_PIX: begin
        eff_w = (int'(pic_width) > pcpd_pkg::MAX_WIDTH) ? pcpd_pkg::MAX_WIDTH :
                int'(pic_width);
        eff_h = (int'(pic_height) > pcpd_pkg::MAX_ROWS) ? pcpd_pkg::MAX_ROWS :
                int'(pic_height);
        row = {1'b0, post_top} + {1'b0, post_index};
        addr_i = int'(row) * eff_w + int'(col);
        res.col = col;
        res.row = row;
        res.addr = addr_i[17:0];
        res.value = data;
        res.overflow = (int'(row) >= eff_h);
        res.write_en = !res.overflow;
        post_left = post_left - 8'd1;
        post_index = post_index + 8'd1;
        if (post_left == 8'd0) parse_state = EXP_PAD2;
        return 1'b1;
      end
      EXP_PAD2: parse_state = EXP_TOP;
      default: parse_state = EXP_DONE;
    endcase
    return 1'b0;
  endfunction

  function automatic string describe(input pixel_result_t r);
    return $sformatf("wr=%b col=%0d row=%0d addr=%0d val=%02h end=%b ovf=%b",
                     r.write_en, r.col, r.row, r.addr, r.value, r.col_end, r.overflow);
  endfunction

  // One byte transaction in bursts with random gaps; queues its result on accept
  task automatic send_byte(input logic [7:0] data, input logic [8:0] col,
                           input logic start, input bit typed, input bit typed_has,
                           input pixel_result_t typed_res);
    int            gap;
    bit            got;
    pixel_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, col, data};
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    got = decode_post_byte(data, col, start, res);
    if (typed) begin
      got = typed_has;
      res = typed_res;
    end
    if (got) pixel_queue.push_back(res);
  endtask

  // Random column: well-formed posts, sometimes broken or followed by stray bytes
  task automatic send_column(input logic [8:0] col, inout int sent);
    logic [7:0] col_bytes [$];
    int         n_posts;
    int         len;
    int         cut;
    n_posts = $urandom_range(0, 4);
    for (int p = 0; p < n_posts; p++) begin
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      col_bytes.push_back(8'($urandom_range(0, 254)));
      col_bytes.push_back(8'(len));
      col_bytes.push_back(8'($urandom));
      repeat (len) col_bytes.push_back(8'($urandom));
      col_bytes.push_back(8'($urandom));
    end
    col_bytes.push_back(pcpd_pkg::TERMINATOR);
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        col_bytes.delete();
        repeat ($urandom_range(1, 20)) col_bytes.push_back(8'($urandom));
      end else begin
        cut = $urandom_range(0, col_bytes.size() - 1);
        while (col_bytes.size() > cut + 1) void'(col_bytes.pop_back());
      end
    end
    foreach (col_bytes[k])
      send_byte(col_bytes[k], col, k == 0, 1'b0, 1'b0, '0);
    sent += col_bytes.size();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), col, 1'b0, 1'b0, 1'b0, '0);
  endtask

  // Drop valid, wait for all results, then let the pipe drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back
  task automatic write_settings(input logic [9:0] width, input logic [9:0] height);
    cfg_valid <= 1'b1;
    cfg_index <= pcpd_pkg::REG_PICTURE_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pic_width = width;
    cfg_index <= pcpd_pkg::REG_PICTURE_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pic_height = height;
    cfg_valid <= 1'b0;
  endtask

  // Receiver: changing ready patterns, plus one long hold-off on request
  initial begin : result_sink
    int mode;
    int len;
    int tick;
    bit rdy;
    tick = 0;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(1, 40);
        repeat (len) begin
          case (mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (tick % 3) != 2;
          endcase
          tick++;
          m_tready <= rdy;
          @(posedge clk);
        end
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    pixel_result_t seen;
    pixel_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.col      = m_tdata[8:0];
      seen.row      = m_tdata[17:9];
      seen.addr     = m_tdata[35:18];
      seen.value    = m_tdata[43:36];
      seen.write_en = m_tuser[0];
      seen.col_end  = m_tuser[1];
      seen.overflow = m_tuser[2];
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result %s", $realtime, describe(seen));
      end else begin
        want = pixel_queue.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch expected %s actual %s", $realtime,
                     describe(want), describe(seen));
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    script_row_t   r;
    pixel_result_t res;
    logic [9:0]    width;
    logic [9:0]    height;
    int            sent;
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= pcpd_pkg::REG_PICTURE_WIDTH;
    cfg_data    <= '0;
    mismatches  = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    parse_state = EXP_TOP;
    post_top    = 8'd0;
    post_left   = 8'd0;
    post_index  = 8'd0;
    pic_width   = 10'd1;
    pic_height  = 10'd1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset settings
    foreach (dir_script[i]) begin
      r = dir_script[i];
      res.write_en = r.write_en;
      res.col      = r.col;
      res.row      = r.row;
      res.addr     = r.addr;
      res.value    = r.col_end ? 8'h00 : r.data;
      res.col_end  = r.col_end;
      res.overflow = r.overflow;
      send_byte(r.data, r.col, r.start, r.typed, r.has_res, res);
    end
    wait_idle();

    // Random columns over several register settings
    for (int p = 0; p < N_PHASES; p++) begin
      width = width_plan[p];
      height = height_plan[p];
      if (p == 5) begin
        width = 10'($urandom_range(1, 512));
        height = 10'($urandom_range(1, 512));
      end
      write_settings(width, height);
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) send_column(9'($urandom_range(0, 511)), sent);
      wait_idle();
    end

    mismatches += pixel_queue.size();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
